// ===== hdl/ilpm_pkg.sv =====
// package: types and constants for the indexed list pool manager
package ilpm_pkg;

    localparam int ENTRIES = 256;
    localparam int IDX_W = 8;

    typedef enum logic [2:0] {
        MODE_CLEAR     = 3'd0,
        MODE_ALLOC     = 3'd1,
        MODE_FREE      = 3'd2,
        MODE_LINK_PREV = 3'd3,
        MODE_LINK_NEXT = 3'd4,
        MODE_PACK      = 3'd5,
        MODE_READ_MAP  = 3'd6,
        MODE_BAD       = 3'd7
    } mode_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    typedef struct packed {
        logic [2:0]       mode;
        logic [IDX_W-1:0] entry_index;
        logic [IDX_W-1:0] other_index;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] result_index;
        logic [IDX_W-1:0] used_count;
        logic             entry_used;
        logic [IDX_W-1:0] entry_next;
        logic [IDX_W-1:0] entry_prev;
    } rsp_t;

    // memory select
    typedef enum logic [1:0] {
        MSEL_NEXT = 2'd0,
        MSEL_PREV = 2'd1,
        MSEL_MAP  = 2'd2,
        MSEL_USED = 2'd3
    } msel_t;

    typedef struct packed {
        logic             rd_en;
        msel_t            rd_sel;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        msel_t            wr_sel;
        logic [IDX_W-1:0] wr_addr;
        logic [IDX_W-1:0] wr_data;
    } mem_cmd_t;

endpackage

// ===== hdl/ilpm_datapath.sv =====
// datapath: link, map and used-mark memories with one read and one write port each
module ilpm_datapath
    import ilpm_pkg::*;
(
    input  logic             clk,
    input  mem_cmd_t         cmd,
    output logic [IDX_W-1:0] rd_data
);

    logic [IDX_W-1:0] next_mem [ENTRIES];
    logic [IDX_W-1:0] prev_mem [ENTRIES];
    logic [IDX_W-1:0] map_mem  [ENTRIES];
    logic             used_mem [ENTRIES];
    logic [IDX_W-1:0] next_q;
    logic [IDX_W-1:0] prev_q;
    logic [IDX_W-1:0] map_q;
    logic             used_q;
    msel_t            sel_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && cmd.wr_sel == MSEL_NEXT)
        begin
            next_mem[cmd.wr_addr] <= cmd.wr_data;
        end
        if (cmd.wr_en && cmd.wr_sel == MSEL_PREV)
        begin
            prev_mem[cmd.wr_addr] <= cmd.wr_data;
        end
        if (cmd.wr_en && cmd.wr_sel == MSEL_MAP)
        begin
            map_mem[cmd.wr_addr] <= cmd.wr_data;
        end
        if (cmd.wr_en && cmd.wr_sel == MSEL_USED)
        begin
            used_mem[cmd.wr_addr] <= cmd.wr_data[0];
        end
        if (cmd.rd_en)
        begin
            next_q  <= next_mem[cmd.rd_addr];
            prev_q  <= prev_mem[cmd.rd_addr];
            map_q   <= map_mem[cmd.rd_addr];
            used_q  <= used_mem[cmd.rd_addr];
            sel_reg <= cmd.rd_sel;
        end
    end

    always_comb
    begin
        unique case (sel_reg)
            MSEL_NEXT: rd_data = next_q;
            MSEL_PREV: rd_data = prev_q;
            MSEL_MAP:  rd_data = map_q;
            MSEL_USED: rd_data = {{(IDX_W-1){1'b0}}, used_q};
            default:   rd_data = '0;
        endcase
    end

endmodule

// ===== hdl/ilpm_ctrl.sv =====
// controller: sequences memory accesses for each mode and builds the response
module ilpm_ctrl
    import ilpm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  req_t             in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output rsp_t             out_data,
    output mem_cmd_t         cmd,
    input  logic [IDX_W-1:0] rd_data
);

    // micro-ops: each step issues at most one read and at most one write
    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_CLR   = 12'b000000000010,
        S_SCAN  = 12'b000000000100,
        S_FREE  = 12'b000000001000,
        S_LINK  = 12'b000000010000,
        S_PK1   = 12'b000000100000,
        S_PKZ   = 12'b000001000000,
        S_PK2   = 12'b000010000000,
        S_RMAP  = 12'b000100000000,
        S_REP   = 12'b001000000000,
        S_OUT   = 12'b010000000000,
        S_WAIT  = 12'b100000000000
    } state_t;

    state_t           state_reg, state_next;
    logic [3:0]       step_reg, step_next;
    logic [IDX_W:0]   i_reg, i_next;
    logic [IDX_W:0]   dst_reg, dst_next;
    logic [IDX_W-1:0] t0_reg, t0_next;
    logic [IDX_W-1:0] t1_reg, t1_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [2:0]       mode_reg, mode_next;
    logic [IDX_W-1:0] a_reg, a_next;
    logic [IDX_W-1:0] b_reg, b_next;
    logic [1:0]       st_reg, st_next;
    logic [IDX_W-1:0] res_reg, res_next;
    logic [IDX_W-1:0] rep_reg, rep_next;
    logic             rep_ok_reg, rep_ok_next;
    rsp_t             out_reg, out_next;
    logic             ov_reg, ov_next;
    logic [IDX_W-1:0] i8;
    logic [IDX_W-1:0] dst8;

    assign i8   = i_reg[IDX_W-1:0];
    assign dst8 = dst_reg[IDX_W-1:0];

    assign in_ready  = (state_reg == S_IDLE) && (!ov_reg || out_ready);
    assign out_valid = ov_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            step_reg       <= '0;
            i_reg          <= '0;
            cnt_reg        <= '0;
            ov_reg         <= 1'b0;
            mode_reg       <= MODE_BAD;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            i_reg          <= i_next;
            cnt_reg        <= cnt_next;
            ov_reg         <= ov_next;
            mode_reg       <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dst_reg    <= dst_next;
        t0_reg     <= t0_next;
        t1_reg     <= t1_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        st_reg     <= st_next;
        res_reg    <= res_next;
        rep_reg    <= rep_next;
        rep_ok_reg <= rep_ok_next;
        out_reg    <= out_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        i_next          = i_reg;
        dst_next        = dst_reg;
        t0_next         = t0_reg;
        t1_next         = t1_reg;
        cnt_next        = cnt_reg;
        mode_next       = mode_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        st_next         = st_reg;
        res_next        = res_reg;
        rep_next        = rep_reg;
        rep_ok_next     = rep_ok_reg;
        out_next        = out_reg;
        ov_next         = ov_reg;
        cmd             = '0;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    mode_next   = in_data.mode;
                    a_next      = in_data.entry_index;
                    b_next      = in_data.other_index;
                    st_next     = ST_OK;
                    res_next    = '0;
                    rep_next    = in_data.entry_index;
                    rep_ok_next = 1'b1;
                    step_next   = '0;
                    i_next      = '0;
                    unique case (in_data.mode)
                        MODE_CLEAR:
                        begin
                            state_next = S_CLR;
                        end
                        MODE_ALLOC:
                        begin
                            i_next     = {{IDX_W{1'b0}}, 1'b1};
                            state_next = S_SCAN;
                        end
                        MODE_FREE:
                        begin
                            state_next = S_FREE;
                        end
                        MODE_LINK_PREV, MODE_LINK_NEXT:
                        begin
                            state_next = S_LINK;
                        end
                        MODE_PACK:
                        begin
                            i_next     = {{IDX_W{1'b0}}, 1'b1};
                            dst_next   = {{IDX_W{1'b0}}, 1'b1};
                            state_next = S_PK1;
                        end
                        MODE_READ_MAP:
                        begin
                            state_next = S_RMAP;
                        end
                        default:
                        begin
                            st_next    = ST_BAD;
                            state_next = S_REP;
                        end
                    endcase
                end
            end

            // clears each entry in all four stores, one store at a time
            S_CLR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = i8;
                cmd.wr_data = '0;
                cmd.wr_sel  = msel_t'(step_reg[1:0]);
                if (step_reg[1:0] == 2'd3)
                begin
                    step_next = '0;
                    if (i8 == IDX_W'(ENTRIES - 1))
                    begin
                        cnt_next   = '0;
                        i_next     = '0;
                        state_next = (mode_reg == MODE_CLEAR) ? S_REP : S_IDLE;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end

            S_SCAN:
            begin
                if (step_reg == 4'd0)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = MSEL_USED;
                    cmd.rd_addr = i8;
                    step_next   = 4'd1;
                end
                else if (step_reg == 4'd1)
                begin
                    if (!rd_data[0])
                    begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_sel  = MSEL_USED;
                        cmd.wr_addr = i8;
                        cmd.wr_data = {{(IDX_W-1){1'b0}}, 1'b1};
                        step_next   = 4'd2;
                    end
                    else if (i8 == IDX_W'(ENTRIES - 1))
                    begin
                        st_next     = ST_FULL;
                        rep_ok_next = 1'b0;
                        state_next  = S_REP;
                    end
                    else
                    begin
                        i_next    = i_reg + 1'b1;
                        step_next = 4'd0;
                    end
                end
                else if (step_reg == 4'd2)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_sel  = MSEL_NEXT;
                    cmd.wr_addr = i8;
                    step_next   = 4'd3;
                end
                else
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_sel  = MSEL_PREV;
                    cmd.wr_addr = i8;
                    cnt_next    = cnt_reg + 1'b1;
                    rep_next    = i8;
                    res_next    = i8;
                    state_next  = S_REP;
                end
            end

            S_FREE:
            begin
                unique case (step_reg)
                    4'd0:
                    begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_sel  = MSEL_USED;
                        cmd.rd_addr = a_reg;
                        step_next   = 4'd1;
                    end
                    4'd1:
                    begin
                        if (a_reg == '0 || !rd_data[0])
                        begin
                            st_next    = ST_BAD;
                            state_next = S_REP;
                        end
                        else
                        begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_sel  = MSEL_NEXT;
                            cmd.rd_addr = a_reg;
                            step_next   = 4'd2;
                        end
                    end
                    4'd2:
                    begin
                        t0_next     = rd_data;
                        cmd.rd_en   = 1'b1;
                        cmd.rd_sel  = MSEL_PREV;
                        cmd.rd_addr = a_reg;
                        step_next   = 4'd3;
                    end
                    4'd3:
                    begin
                        t1_next = rd_data;
                        if (rd_data != '0)
                        begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_sel  = MSEL_NEXT;
                            cmd.wr_addr = rd_data;
                            cmd.wr_data = t0_reg;
                        end
                        step_next = 4'd4;
                    end
                    4'd4:
                    begin
                        if (t0_reg != '0)
                        begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_sel  = MSEL_PREV;
                            cmd.wr_addr = t0_reg;
                            cmd.wr_data = t1_reg;
                        end
                        step_next = 4'd5;
                    end
                    default:
                    begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_sel  = MSEL_USED;
                        cmd.wr_addr = a_reg;
                        cmd.wr_data = '0;
                        cnt_next    = cnt_reg - 1'b1;
                        state_next  = S_REP;
                    end
                endcase
            end

            S_LINK:
            begin
                unique case (step_reg)
                    4'd0:
                    begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_sel  = MSEL_USED;
                        cmd.rd_addr = a_reg;
                        step_next   = 4'd1;
                    end
                    4'd1:
                    begin
                        if (a_reg == '0 || b_reg == '0 || a_reg == b_reg || !rd_data[0])
                        begin
                            st_next    = ST_BAD;
                            state_next = S_REP;
                        end
                        else
                        begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_sel  = MSEL_USED;
                            cmd.rd_addr = b_reg;
                            step_next   = 4'd2;
                        end
                    end
                    4'd2:
                    begin
                        if (!rd_data[0])
                        begin
                            st_next    = ST_BAD;
                            state_next = S_REP;
                        end
                        else
                        begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_sel  = (mode_reg == MODE_LINK_PREV) ? MSEL_PREV : MSEL_NEXT;
                            cmd.rd_addr = b_reg;
                            step_next   = 4'd3;
                        end
                    end
                    4'd3:
                    begin
                        // n = neighbor of b; a takes n on the same side
                        t0_next     = rd_data;
                        cmd.wr_en   = 1'b1;
                        cmd.wr_sel  = (mode_reg == MODE_LINK_PREV) ? MSEL_PREV : MSEL_NEXT;
                        cmd.wr_addr = a_reg;
                        cmd.wr_data = rd_data;
                        step_next   = 4'd4;
                    end
                    4'd4:
                    begin
                        if (t0_reg != '0)
                        begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_sel  = (mode_reg == MODE_LINK_PREV) ? MSEL_NEXT : MSEL_PREV;
                            cmd.wr_addr = t0_reg;
                            cmd.wr_data = a_reg;
                        end
                        step_next = 4'd5;
                    end
                    4'd5:
                    begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_sel  = (mode_reg == MODE_LINK_PREV) ? MSEL_PREV : MSEL_NEXT;
                        cmd.wr_addr = b_reg;
                        cmd.wr_data = a_reg;
                        step_next   = 4'd6;
                    end
                    default:
                    begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_sel  = (mode_reg == MODE_LINK_PREV) ? MSEL_NEXT : MSEL_PREV;
                        cmd.wr_addr = a_reg;
                        cmd.wr_data = b_reg;
                        state_next  = S_REP;
                    end
                endcase
            end

            // compaction pass: dst never exceeds i, so moving in place is safe
            S_PK1:
            begin
                unique case (step_reg)
                    4'd0:
                    begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_sel  = MSEL_USED;
                        cmd.rd_addr = i8;
                        step_next   = 4'd1;
                    end
                    4'd1:
                    begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_sel  = MSEL_MAP;
                        cmd.wr_addr = i8;
                        cmd.wr_data = rd_data[0] ? dst8 : '0;
                        if (rd_data[0])
                        begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_sel  = MSEL_NEXT;
                            cmd.rd_addr = i8;
                            step_next   = 4'd2;
                        end
                        else
                        begin
                            step_next = 4'd6;
                        end
                    end
                    4'd2:
                    begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_sel  = MSEL_NEXT;
                        cmd.wr_addr = dst8;
                        cmd.wr_data = rd_data;
                        cmd.rd_en   = 1'b1;
                        cmd.rd_sel  = MSEL_PREV;
                        cmd.rd_addr = i8;
                        step_next   = 4'd3;
                    end
                    4'd3:
                    begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_sel  = MSEL_PREV;
                        cmd.wr_addr = dst8;
                        cmd.wr_data = rd_data;
                        step_next   = 4'd4;
                    end
                    4'd4:
                    begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_sel  = MSEL_USED;
                        cmd.wr_addr = dst8;
                        cmd.wr_data = {{(IDX_W-1){1'b0}}, 1'b1};
                        dst_next    = dst_reg + 1'b1;
                        step_next   = 4'd6;
                    end
                    default:
                    begin
                        step_next = 4'd0;
                        if (i8 == IDX_W'(ENTRIES - 1))
                        begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_sel  = MSEL_MAP;
                            cmd.wr_addr = '0;
                            cmd.wr_data = '0;
                            cnt_next    = IDX_W'(dst_reg - 1'b1);
                            i_next      = dst_reg;
                            state_next  = (dst_reg == (IDX_W+1)'(ENTRIES)) ? S_PK2 : S_PKZ;
                            if (dst_reg == (IDX_W+1)'(ENTRIES))
                            begin
                                i_next = {{IDX_W{1'b0}}, 1'b1};
                            end
                        end
                        else
                        begin
                            i_next = i_reg + 1'b1;
                        end
                    end
                endcase
            end

            S_PKZ:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = i8;
                cmd.wr_data = '0;
                unique case (step_reg[1:0])
                    2'd0:    cmd.wr_sel = MSEL_USED;
                    2'd1:    cmd.wr_sel = MSEL_NEXT;
                    default: cmd.wr_sel = MSEL_PREV;
                endcase
                if (step_reg[1:0] == 2'd2)
                begin
                    step_next = '0;
                    if (i8 == IDX_W'(ENTRIES - 1))
                    begin
                        i_next     = {{IDX_W{1'b0}}, 1'b1};
                        state_next = S_PK2;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end

            // rewrite links of entries 1..dst-1 through the map
            S_PK2:
            begin
                if (i_reg >= dst_reg)
                begin
                    state_next = S_REP;
                end
                else
                begin
                    unique case (step_reg)
                        4'd0:
                        begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_sel  = MSEL_NEXT;
                            cmd.rd_addr = i8;
                            step_next   = 4'd1;
                        end
                        4'd1:
                        begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_sel  = MSEL_MAP;
                            cmd.rd_addr = rd_data;
                            step_next   = 4'd2;
                        end
                        4'd2:
                        begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_sel  = MSEL_NEXT;
                            cmd.wr_addr = i8;
                            cmd.wr_data = rd_data;
                            cmd.rd_en   = 1'b1;
                            cmd.rd_sel  = MSEL_PREV;
                            cmd.rd_addr = i8;
                            step_next   = 4'd3;
                        end
                        4'd3:
                        begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_sel  = MSEL_MAP;
                            cmd.rd_addr = rd_data;
                            step_next   = 4'd4;
                        end
                        default:
                        begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_sel  = MSEL_PREV;
                            cmd.wr_addr = i8;
                            cmd.wr_data = rd_data;
                            step_next   = 4'd0;
                            i_next      = i_reg + 1'b1;
                        end
                    endcase
                end
            end

            S_RMAP:
            begin
                if (step_reg == 4'd0)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = MSEL_MAP;
                    cmd.rd_addr = a_reg;
                    step_next   = 4'd1;
                end
                else
                begin
                    res_next   = rd_data;
                    state_next = S_REP;
                end
            end

            // read the reported entry: used, next, prev
            S_REP:
            begin
                step_next = '0;
                if (!(step_reg == 4'd0))
                begin
                    step_next = step_reg;
                end
                unique case (step_reg)
                    4'd0:
                    begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_sel  = MSEL_USED;
                        cmd.rd_addr = rep_reg;
                        step_next   = 4'd1;
                    end
                    4'd1:
                    begin
                        out_next.entry_used = rd_data[0] & rep_ok_reg;
                        cmd.rd_en   = 1'b1;
                        cmd.rd_sel  = MSEL_NEXT;
                        cmd.rd_addr = rep_reg;
                        step_next   = 4'd2;
                    end
                    4'd2:
                    begin
                        out_next.entry_next = rep_ok_reg ? rd_data : '0;
                        cmd.rd_en   = 1'b1;
                        cmd.rd_sel  = MSEL_PREV;
                        cmd.rd_addr = rep_reg;
                        step_next   = 4'd3;
                    end
                    default:
                    begin
                        out_next.entry_prev   = rep_ok_reg ? rd_data : '0;
                        out_next.status       = st_reg;
                        out_next.result_index = res_reg;
                        out_next.used_count   = cnt_reg;
                        step_next             = '0;
                        state_next            = S_OUT;
                    end
                endcase
            end

            S_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    state_next = S_WAIT;
                end
            end

            S_WAIT:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // the report sequence always starts at its first read
        if (state_next == S_REP && state_reg != S_REP)
        begin
            step_next = '0;
        end

        if (state_reg == S_OUT && ov_reg && !out_ready)
        begin
            ov_next = 1'b1;
        end
    end

endmodule

// ===== hdl/indexed_list_pool_manager_top.sv =====
// indexed list pool manager: linked entry pool with allocate, free, link, pack, clear and read map
// usage:
//   requests arrive on the in channel (valid/ready) as one req_t transaction
//   each request produces exactly one rsp_t transaction on the out channel
//   one request is worked on at a time; in_ready is high only when idle
//   after reset the controller clears all memories, one store entry per cycle,
//   before in_ready first rises
//   the result is held in an output register; if the receiver stalls it
//   stays valid and stable and no new request is taken until it leaves
//   the used count is kept in a register and reported with every result
module indexed_list_pool_manager_top
    import ilpm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  req_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output rsp_t out_data
);

    mem_cmd_t         cmd;
    logic [IDX_W-1:0] rd_data;

    ilpm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cmd       (cmd),
        .rd_data   (rd_data)
    );

    ilpm_datapath u_dp (
        .clk     (clk),
        .cmd     (cmd),
        .rd_data (rd_data)
    );

endmodule
